// ===== design/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants for the greedy box NMS block
// Transaction payloads, the kept-store entry layout and register indexes.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned MAX_KEPT_DEFAULT = 256;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_AGNOSTIC = 1'b1;

  localparam logic [15:0] IOU_THRESHOLD_RESET  = 16'd32768;
  localparam logic        CLASS_AGNOSTIC_RESET = 1'b0;

  typedef struct packed {
    logic        first_box;
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [7:0]  class_label;
  } box_in_t;

  typedef struct packed {
    logic       keep;
    logic       overflow;
    logic [8:0] kept_total;
  } box_out_t;

  // One entry of the kept list: geometry, label and area side by side.
  typedef struct packed {
    logic [7:0]  label;
    logic [31:0] area;
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } kept_entry_t;

  // Status returned by the overlap pipeline to the sequencer.
  typedef struct packed {
    logic busy;
    logic drop;
  } cmp_status_t;

endpackage

// ===== design/gbn_iou.sv =====
// ----------------------------------------------------------------------------
// gbn_iou: pipelined IoU suppression test
// Compares the current box with one kept entry per cycle and flags a drop.
// ----------------------------------------------------------------------------
module gbn_iou (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                entry_valid_i,
  input  gbn_pkg::kept_entry_t entry_i,
  input  gbn_pkg::box_in_t    box_i,
  input  logic [31:0]         box_area_i,
  input  logic [15:0]         iou_threshold_i,
  input  logic                class_agnostic_i,
  output gbn_pkg::cmp_status_t status_o
);
  import gbn_pkg::*;

  // Stage A: per-axis overlaps and class match.
  logic        va_q;
  logic [15:0] ox_q, oy_q;
  logic [31:0] area_b_a_q;
  logic [15:0] ox_d, oy_d;
  logic        match_d;

  // Stage B: intersection.
  logic        vb_q;
  logic [31:0] inter_b_q, area_b_b_q;

  // Stage C: union.
  logic        vc_q;
  logic [31:0] inter_c_q;
  logic [32:0] uni_c_q;

  // Stage D: threshold times union.
  logic        vd_q;
  logic [31:0] inter_d_q;
  logic [48:0] prod_d_q;
  logic        uni_nz_d_q;

  logic        drop_q;

  function automatic logic [15:0] axis_overlap(logic [15:0] a0, logic [15:0] alen,
                                               logic [15:0] b0, logic [15:0] blen);
    logic [16:0] a1, b1, lo, hi, diff;
    a1   = {1'b0, a0} + {1'b0, alen};
    b1   = {1'b0, b0} + {1'b0, blen};
    lo   = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi   = (a1 < b1) ? a1 : b1;
    diff = hi - lo;
    // The overlap never exceeds the shorter length, so 16 bits hold it.
    return (hi > lo) ? diff[15:0] : 16'd0;
  endfunction

  always_comb begin
    ox_d    = axis_overlap(box_i.box_x, box_i.box_width, entry_i.x, entry_i.w);
    oy_d    = axis_overlap(box_i.box_y, box_i.box_height, entry_i.y, entry_i.h);
    match_d = class_agnostic_i || (entry_i.label == box_i.class_label);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      vd_q   <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      va_q   <= entry_valid_i && match_d;
      vb_q   <= va_q;
      vc_q   <= vb_q;
      vd_q   <= vc_q;
      drop_q <= vd_q && uni_nz_d_q && ({1'b0, inter_d_q, 16'd0} > prod_d_q);
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q       <= ox_d;
    oy_q       <= oy_d;
    area_b_a_q <= entry_i.area;

    inter_b_q  <= 32'(ox_q) * 32'(oy_q);
    area_b_b_q <= area_b_a_q;

    inter_c_q  <= inter_b_q;
    uni_c_q    <= {1'b0, box_area_i} + {1'b0, area_b_b_q} - {1'b0, inter_b_q};

    inter_d_q  <= inter_c_q;
    prod_d_q   <= {33'd0, iou_threshold_i} * {16'd0, uni_c_q};
    uni_nz_d_q <= (uni_c_q != 33'd0);
  end

  assign status_o.busy = va_q || vb_q || vc_q || vd_q;
  assign status_o.drop = drop_q;

endmodule

// ===== design/greedy_box_nms.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms: greedy non-maximum suppression over a stream of boxes
// Each box is compared with every box kept before it in the frame (up to MAX_KEPT),
// read from the kept list one entry per cycle; with an empty list the sweep is skipped.
// A new box is taken only once the result of the last one is loaded, so a
// stalled result delays the next one.
// Reset clears the control, the kept count and the registers to their
// defaults; the kept-list memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module greedy_box_nms #(
  parameter int unsigned MAX_KEPT = gbn_pkg::MAX_KEPT_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input channel: one candidate box per transaction.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gbn_pkg::box_in_t               in_data_i,
  // Output channel: one result per box.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gbn_pkg::box_out_t              out_data_o
);
  import gbn_pkg::*;

  localparam int unsigned CW = $clog2(MAX_KEPT + 1);  // kept count width
  localparam int unsigned IW = $clog2(MAX_KEPT);      // memory index width

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e      state_q, state_d;

  // Configuration registers.
  logic [15:0] iou_threshold_q;
  logic        class_agnostic_q;

  // Current box and its area, captured when the input transaction is taken.
  box_in_t     box_q;
  logic [31:0] area_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          drop_q, drop_d;

  logic          out_valid_q, out_valid_d;
  box_out_t      out_data_q, out_data_d;

  // Kept-list memory: one synchronous write port, one registered read port.
  kept_entry_t   kept_mem [MAX_KEPT];
  kept_entry_t   rd_data_q;
  logic          rd_valid_q;
  logic          rd_en;
  logic          wr_en;
  kept_entry_t   wr_data;

  cmp_status_t   cmp_status;

  logic          in_accept;
  logic          out_free;
  logic          can_store;
  logic [CW-1:0] start_count;

  // --------------------------------------------------------------------------
  // Configuration. The user must write only while the block is idle; the block itself does not enforce it.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iou_threshold_q  <= IOU_THRESHOLD_RESET;
      class_agnostic_q <= CLASS_AGNOSTIC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IOU_THRESHOLD:  iou_threshold_q  <= cfg_wdata_i[15:0];
        CFG_CLASS_AGNOSTIC: class_agnostic_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. A box is taken in IDLE; SWEEP reads every kept entry once and
  // feeds it to the compare pipeline; DRAIN waits for the last compare to
  // come out; OUT updates the kept list and loads the output register.
  // The kept list only changes in OUT, after all reads of this box are done,
  // so a read and a write of the same entry never overlap.
  // --------------------------------------------------------------------------
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign start_count = in_data_i.first_box ? '0 : count_q;
  assign can_store   = (count_q < CW'(MAX_KEPT));
  assign rd_en       = (state_q == ST_SWEEP);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    drop_d      = drop_q || cmp_status.drop;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    wr_en       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          // A first box empties the kept list before it is compared.
          count_d  = start_count;
          rd_idx_d = '0;
          drop_d   = 1'b0;
          state_d  = (start_count == '0) ? ST_DRAIN : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        rd_idx_d = rd_idx_q + CW'(1);
        if (rd_idx_q + CW'(1) == count_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !cmp_status.busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_data_d.keep     = !drop_q;
          out_data_d.overflow = !drop_q && !can_store;
          if (!drop_q && can_store) begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
          out_data_d.kept_total = 9'(count_d);
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      rd_valid_q  <= rd_en;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      box_q  <= in_data_i;
      area_q <= 32'(in_data_i.box_width) * 32'(in_data_i.box_height);
    end
    out_data_q <= out_data_d;
  end

  // --------------------------------------------------------------------------
  // Kept-list memory.
  // --------------------------------------------------------------------------
  always_comb begin
    wr_data.label = box_q.class_label;
    wr_data.area  = area_q;
    wr_data.h     = box_q.box_height;
    wr_data.w     = box_q.box_width;
    wr_data.y     = box_q.box_y;
    wr_data.x     = box_q.box_x;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      kept_mem[count_q[IW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= kept_mem[rd_idx_q[IW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // IoU compare pipeline, one kept entry per cycle.
  // --------------------------------------------------------------------------
  gbn_iou u_iou (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .entry_valid_i    (rd_valid_q),
    .entry_i          (rd_data_q),
    .box_i            (box_q),
    .box_area_i       (area_q),
    .iou_threshold_i  (iou_threshold_q),
    .class_agnostic_i (class_agnostic_q),
    .status_o         (cmp_status)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/box_nms_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_nms_checker: prediction and comparison for the greedy box NMS block
// Watches the register writes and both transaction channels, keeps its own
// kept-box list, predicts one verdict per accepted box and compares each
// accepted result with the oldest verdict still due.
// ----------------------------------------------------------------------------
module box_nms_checker #(
  parameter int unsigned MAX_KEPT = gbn_pkg::MAX_KEPT_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  gbn_pkg::box_in_t               in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  gbn_pkg::box_out_t              out_data_i,
  output int                             mismatch_count_o,
  output int                             results_seen_o
);
  import gbn_pkg::*;

  kept_entry_t  kept_list [MAX_KEPT];
  int unsigned  kept_n;
  logic [15:0]  iou_limit;
  logic         any_class;
  box_out_t     verdicts_due [$];
  box_out_t     oldest;
  box_out_t     fresh;
  int           mismatches = 0;
  int           results_n = 0;

  // Overlap of two spans on one axis; right edges are 17 bits wide so they never wrap.
  function automatic logic [63:0] span_overlap(input logic [15:0] a0, input logic [15:0] a_len,
                                               input logic [15:0] b0, input logic [15:0] b_len);
    logic [16:0] a1, b1, lo, hi;
    a1 = {1'b0, a0} + {1'b0, a_len};
    b1 = {1'b0, b0} + {1'b0, b_len};
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? 64'(hi - lo) : 64'd0;
  endfunction

  // Runs one box against the kept list, updates the list and returns its verdict.
  function automatic box_out_t judge_box(input box_in_t b);
    logic [31:0] area;
    logic [63:0] inter, uni;
    logic        keep;
    int unsigned k;
    box_out_t    v;
    area = 32'(b.box_width) * 32'(b.box_height);
    if (b.first_box) kept_n = 0;
    keep = 1'b1;
    for (k = 0; k < kept_n; k++) begin
      if (any_class || kept_list[k].label == b.class_label) begin
        inter = span_overlap(b.box_x, b.box_width, kept_list[k].x, kept_list[k].w) *
                span_overlap(b.box_y, b.box_height, kept_list[k].y, kept_list[k].h);
        uni = 64'(area) + 64'(kept_list[k].area) - inter;
        if (uni != 64'd0 && (inter << 16) > 64'(iou_limit) * uni) keep = 1'b0;
      end
    end
    v.keep = keep;
    v.overflow = 1'b0;
    if (keep) begin
      if (kept_n < MAX_KEPT) begin
        kept_list[kept_n] = '{label: b.class_label, area: area, h: b.box_height,
                              w: b.box_width, y: b.box_y, x: b.box_x};
        kept_n++;
      end else begin
        v.overflow = 1'b1;
      end
    end
    v.kept_total = 9'(kept_n);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_n = 0;
      iou_limit = IOU_THRESHOLD_RESET;
      any_class = CLASS_AGNOSTIC_RESET;
      verdicts_due.delete();
      mismatch_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      // A result can never belong to a box accepted at the same edge, so check it first.
      if (out_valid_i && !out_stall_i) begin
        results_n++;
        if (verdicts_due.size() == 0) begin
          $error("result with no box outstanding: keep=%0b overflow=%0b kept_total=%0d",
                 out_data_i.keep, out_data_i.overflow, out_data_i.kept_total);
          mismatches++;
        end else begin
          oldest = verdicts_due.pop_front();
          if (out_data_i.keep !== oldest.keep) begin
            $error("keep: expected %0b, actual %0b", oldest.keep, out_data_i.keep);
            mismatches++;
          end
          if (out_data_i.overflow !== oldest.overflow) begin
            $error("overflow: expected %0b, actual %0b", oldest.overflow, out_data_i.overflow);
            mismatches++;
          end
          if (out_data_i.kept_total !== oldest.kept_total) begin
            $error("kept_total: expected %0d, actual %0d", oldest.kept_total,
                   out_data_i.kept_total);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IOU_THRESHOLD:  iou_limit = cfg_wdata_i;
          CFG_CLASS_AGNOSTIC: any_class = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        fresh = judge_box(in_data_i);
        verdicts_due = {verdicts_due, fresh};
      end
      mismatch_count_o <= mismatches;
      results_seen_o <= results_n;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the greedy box NMS block
// Sends a short directed set of boxes under the reset and extreme register
// settings, then runs random frames of clustered boxes mixed with noise while
// both channels idle at random, driving the kept store past its capacity once.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import gbn_pkg::*;

  localparam int unsigned MAX_KEPT   = MAX_KEPT_DEFAULT;
  localparam int          BOX_TARGET = 1900;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  box_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  box_out_t              out_data;

  int          mismatch_count;
  int          results_seen;
  int          boxes_sent = 0;
  // Upper bounds of the random idle cycles on each side; zero gives a stretch
  // where that side never idles.
  int unsigned in_gap_max = 8;
  int unsigned out_hold_max = 8;

  always #5 clk = ~clk;

  greedy_box_nms #(
    .MAX_KEPT(MAX_KEPT)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  box_nms_checker #(
    .MAX_KEPT(MAX_KEPT)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .results_seen_o  (results_seen)
  );

  function automatic box_in_t mk_box(input logic fb, input logic [15:0] x, input logic [15:0] y,
                                     input logic [15:0] w, input logic [15:0] h,
                                     input logic [7:0] label);
    box_in_t b;
    b.first_box = fb;
    b.box_x = x;
    b.box_y = y;
    b.box_width = w;
    b.box_height = h;
    b.class_label = label;
    return b;
  endfunction

  // Moves a value by up to span either way, clamped to the 16-bit field.
  function automatic logic [15:0] nudge(input logic [15:0] v, input int unsigned span);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return 16'(t);
  endfunction

  // One input transaction. Valid is lowered only when a gap is drawn, so a
  // back-to-back transaction never lowers and raises it in the same step.
  task automatic send_box(input box_in_t b);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    boxes_sent++;
  endtask

  // Waits until every box sent so far has produced its result. The checker's
  // count is registered and lags behind, so this never returns early.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_seen < boxes_sent) @(posedge clk);
  endtask

  // Registers are only written with the block idle; both go in on back-to-back edges.
  task automatic program_regs(input logic [15:0] thr, input logic agn);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_IOU_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_idx <= CFG_CLASS_AGNOSTIC;
    cfg_wdata <= {15'd0, agn};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A frame of boxes scattered around a few objects, so that suppression
  // actually happens. About one box in ten is pure noise with random fields,
  // including a random first-box flag that breaks up the frame.
  task automatic run_frame(input int unsigned len);
    logic [15:0] ax [4];
    logic [15:0] ay [4];
    logic [15:0] aw [4];
    logic [15:0] ah [4];
    logic [7:0]  al [4];
    logic [7:0]  base;
    int unsigned n_obj, o, i;
    box_in_t     b;
    n_obj = $urandom_range(1, 4);
    base = 8'($urandom);
    for (o = 0; o < 4; o++) begin
      ax[o] = 16'($urandom);
      ay[o] = 16'($urandom);
      aw[o] = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(16, 4000));
      ah[o] = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(16, 4000));
      al[o] = base + 8'($urandom_range(0, 1));
    end
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        b = mk_box(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom));
      end else begin
        o = $urandom_range(0, n_obj - 1);
        b = mk_box(i == 0, nudge(ax[o], aw[o] / 4 + 1), nudge(ay[o], ah[o] / 4 + 1),
                   nudge(aw[o], aw[o] / 8 + 1), nudge(ah[o], ah[o] / 8 + 1), al[o]);
        // Degenerate boxes now and then: they neither suppress nor get suppressed.
        if ($urandom_range(0, 19) == 0) b.box_width = '0;
        if ($urandom_range(0, 19) == 0) b.box_height = '0;
      end
      send_box(b);
    end
  endtask

  // Fills the kept store with disjoint boxes, one per grid cell, then keeps
  // sending: new disjoint boxes must report overflow, while repeats of stored
  // boxes must still be dropped without overflow.
  task automatic fill_store();
    box_in_t     grid [MAX_KEPT];
    box_in_t     b;
    int unsigned k;
    program_regs(16'($urandom), 1'($urandom));
    for (k = 0; k < MAX_KEPT + 24; k++) begin
      if (k < MAX_KEPT || k % 2 == 0) begin
        b = mk_box(k == 0, 16'((k % 16) * 1024 + $urandom_range(0, 200)),
                   16'((k / 16) * 1024 + $urandom_range(0, 200)),
                   16'($urandom_range(16, 800)), 16'($urandom_range(16, 800)), 8'($urandom));
        if (k < MAX_KEPT) grid[k] = b;
      end else begin
        b = grid[$urandom_range(0, MAX_KEPT - 1)];
        b.first_box = 1'b0;
      end
      send_box(b);
    end
  endtask

  // Result side: after each accepted result, a hold of 0 to out_hold_max is
  // drawn. A nonzero hold raises stall, which is then counted down at each edge
  // at which a result is waiting and lowered when the hold runs out.
  initial begin
    int unsigned hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) begin
        hold = $urandom_range(0, out_hold_max);
        if (hold != 0) out_stall <= 1'b1;
      end else if (out_valid === 1'b1 && out_stall) begin
        if (hold > 1) hold--;
        else out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic        filled;
    logic [15:0] thr;
    filled = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: threshold one half, same class only.
    send_box(mk_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));       // zero-size box
    send_box(mk_box(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));       // zero union
    send_box(mk_box(1'b0, 16'd0, 16'd0, 16'd16, 16'd16, 8'd0));
    send_box(mk_box(1'b0, 16'd0, 16'd0, 16'd16, 16'd16, 8'd0));     // identical, dropped
    send_box(mk_box(1'b0, 16'd0, 16'd0, 16'd16, 16'd16, 8'd1));     // other class
    send_box(mk_box(1'b0, 16'd8, 16'd0, 16'd16, 16'd16, 8'd0));     // IoU one third
    send_box(mk_box(1'b0, 16'd4, 16'd0, 16'd16, 16'd16, 8'd0));     // IoU 0.6
    send_box(mk_box(1'b0, 16'd0, 16'd0, 16'd8, 16'd16, 8'd0));      // IoU exactly half
    send_box(mk_box(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_box(mk_box(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_box(mk_box(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'hFF)); // corner touch only
    send_box(mk_box(1'b1, 16'd0, 16'd0, 16'd16, 16'd16, 8'd0));     // new frame
    send_box(mk_box(1'b0, 16'd0, 16'd0, 16'd16, 16'd16, 8'd0));

    // Zero threshold, all classes: any real overlap suppresses.
    program_regs(16'h0000, 1'b1);
    send_box(mk_box(1'b1, 16'd0, 16'd0, 16'd16, 16'd16, 8'd3));
    send_box(mk_box(1'b0, 16'd16, 16'd0, 16'd16, 16'd16, 8'd4));    // edges touch
    send_box(mk_box(1'b0, 16'd31, 16'd15, 16'd16, 16'd16, 8'd9));   // one unit of overlap
    send_box(mk_box(1'b0, 16'd8, 16'd8, 16'd0, 16'd0, 8'd3));       // zero-size inside

    // Full threshold: only an exact duplicate goes.
    program_regs(16'hFFFF, 1'b0);
    send_box(mk_box(1'b1, 16'd100, 16'd100, 16'd48, 16'd48, 8'd7));
    send_box(mk_box(1'b0, 16'd100, 16'd100, 16'd48, 16'd48, 8'd7));
    send_box(mk_box(1'b0, 16'd101, 16'd100, 16'd48, 16'd48, 8'd7));

    // Random phases, each with its own registers and idling; the store is
    // driven past full once along the way.
    while (boxes_sent < BOX_TARGET) begin
      case ($urandom_range(0, 5))
        0:       thr = 16'h0000;
        1:       thr = 16'hFFFF;
        2:       thr = 16'h8000;
        3:       thr = 16'($urandom);
        4:       thr = 16'($urandom_range(8192, 24576));
        default: thr = 16'($urandom_range(40000, 60000));
      endcase
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      out_hold_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      program_regs(thr, 1'($urandom));
      repeat ($urandom_range(6, 14)) begin
        run_frame(($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24));
      end
      if (!filled && boxes_sent > 800) begin
        fill_store();
        filled = 1'b1;
      end
    end

    // Drain, then leave room for any stray result before the verdict.
    settle();
    repeat (MAX_KEPT + 16) @(posedge clk);
    if (mismatch_count == 0 && results_seen == boxes_sent) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run of every box against a
  // full store with the longest idles on both sides.
  initial begin
    #100000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
